### design/mdo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the momentum disturbance observer.
// Holds the microcode control word, status bundle and configuration record.
// No dependencies; every other design file imports this package.
package mdo_pkg;

	// Fixed field widths and fixed-point formats.
	localparam int CH_W       = 3;
	localparam int GAIN_W     = 32;
	localparam int COEF_W     = 25;
	localparam int FRAC_GAIN  = 16;
	localparam int FRAC_COEF  = 24;
	localparam int MUL_DIGIT  = 32;
	localparam int PC_W       = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Channels below this index are linear, the rest are angular.
	localparam logic [CH_W-1:0] LIN_CHANNELS = 3'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_CORR_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_CORR_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_ON = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRATE_ON  = 3'd7;

	// Datapath operation performed by one microcode step.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_RES,
		OP_MLD,
		OP_MAC,
		OP_RND,
		OP_CLRP,
		OP_GSET,
		OP_DINT,
		OP_RATE,
		OP_MOM,
		OP_FILT,
		OP_EMIT
	} op_t;

	// Multiplier operand A source.
	typedef enum logic [1:0] {
		A_R,
		A_D,
		A_RATE,
		A_DF
	} asel_t;

	// Multiplier operand B source.
	typedef enum logic [1:0] {
		B_GAIN,
		B_STEP,
		B_CGAIN,
		B_SMOOTH
	} bsel_t;

	// Sequencer branch condition.
	typedef enum logic [2:0] {
		COND_NEXT,
		COND_NOT_INT,
		COND_NOT_CORR,
		COND_MUL_MORE,
		COND_END
	} cond_t;

	typedef struct packed {
		op_t             op;
		asel_t           asel;
		bsel_t           bsel;
		logic            frac24;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic integrate_on;
		logic correction_on;
		logic mul_last;
		logic out_full;
	} stat_t;

	typedef struct packed {
		logic [GAIN_W-1:0] force_gain;
		logic [GAIN_W-1:0] torque_gain;
		logic [GAIN_W-1:0] lin_corr_gain;
		logic [GAIN_W-1:0] ang_corr_gain;
		logic [COEF_W-1:0] step_time;
		logic [COEF_W-1:0] smoothing;
		logic              correction_on;
		logic              integrate_on;
	} cfg_t;

endpackage

### design/momentum_disturbance_observer.sv
`timescale 1ns / 1ps
// Momentum disturbance observer top level: stream ports, register file,
// microcode sequencer and datapath.
// Depends on mdo_pkg, mdo_seq and mdo_datapath.
//
// Usage: each input beat on the s_ channel is one observer update for one
// channel (tuser = channel, tdata = measured momentum, drive, bias). Channels
// 0-2 use the linear gains, higher channels the angular gains. A beat whose
// channel is not below CHANNELS is taken and dropped without a result.
// Every other beat gives one m_ beat with the filtered external estimate,
// the raw disturbance estimate, the channel and a clip flag.
// A microcoded sequencer runs the update over one shared multiplier that
// takes one 32-bit digit of its operand per cycle. Each product costs
// 2 + ceil((DATA_WIDTH+2)/32) steps, the other work seven steps, eight with
// integration, and three to five products run depending on the mode bits.
// No new beat is taken before an item's result has been placed in the
// output register; s_tready is low while an item runs.
// A result waits in the output register; a stalled receiver holds the final
// step only if a new result is ready before the old one has been taken.
// Reset clears all channel state to zero and loads the register defaults.
// Configuration beats are always taken and are meant for an idle block.
module momentum_disturbance_observer #(
	parameter int CHANNELS   = 6,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// bits from 0: measured_momentum, drive, bias, zero fill
	input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
	// bits from 0: channel
	input  logic [mdo_pkg::CH_W-1:0]                 s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// bits from 0: external_estimate, raw_estimate, zero fill
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]        m_tdata,
	// bits from 0: channel_out, saturated
	output logic [mdo_pkg::CH_W:0]                   m_tuser,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [mdo_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [mdo_pkg::CFG_DATA_W-1:0]           cfg_data
);
	import mdo_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int OUT_W = ((2*DATA_WIDTH+7)/8)*8;
	localparam logic [CH_W+1:0] CH_LIMIT = (CH_W+2)'(CHANNELS);

	cfg_t                cfg_q;
	ctl_t                ctl;
	stat_t               stat;
	logic                busy;
	logic                start;
	logic [CH_W-1:0]     out_channel;
	logic signed [W-1:0] out_external;
	logic signed [W-1:0] out_raw;
	logic                out_saturated;

	// Register writes; every index is defined.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.force_gain    <= 32'd327680;
			cfg_q.torque_gain   <= 32'd1310720;
			cfg_q.lin_corr_gain <= 32'd131072;
			cfg_q.ang_corr_gain <= 32'd655360;
			cfg_q.step_time     <= 25'd67109;
			cfg_q.smoothing     <= 25'd3355443;
			cfg_q.correction_on <= 1'b0;
			cfg_q.integrate_on  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FORCE_GAIN:    cfg_q.force_gain    <= cfg_data;
				REG_TORQUE_GAIN:   cfg_q.torque_gain   <= cfg_data;
				REG_LIN_CORR_GAIN: cfg_q.lin_corr_gain <= cfg_data;
				REG_ANG_CORR_GAIN: cfg_q.ang_corr_gain <= cfg_data;
				REG_STEP_TIME:     cfg_q.step_time     <= cfg_data[COEF_W-1:0];
				REG_SMOOTHING:     cfg_q.smoothing     <= cfg_data[COEF_W-1:0];
				REG_CORRECTION_ON: cfg_q.correction_on <= cfg_data[0];
				REG_INTEGRATE_ON:  cfg_q.integrate_on  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// A beat for a channel that exists starts the program.
	assign s_tready = !busy;
	assign start    = s_tvalid && s_tready && ((CH_W+2)'(s_tuser) < CH_LIMIT);

	mdo_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	mdo_datapath #(
		.CHANNELS   (CHANNELS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.in_channel    (s_tuser),
		.in_meas       (s_tdata[W-1:0]),
		.in_drive      (s_tdata[2*W-1:W]),
		.in_bias       (s_tdata[3*W-1:2*W]),
		.cfg           (cfg_q),
		.ctl           (ctl),
		.stat          (stat),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_channel   (out_channel),
		.out_external  (out_external),
		.out_raw       (out_raw),
		.out_saturated (out_saturated)
	);

	// Output beat packing.
	assign m_tdata = OUT_W'({out_raw, out_external});
	assign m_tuser = {out_saturated, out_channel};

endmodule

### design/mdo_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program ROM and branch logic.
// Depends on mdo_pkg for the control word and status types.
module mdo_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mdo_pkg::stat_t stat,
	output mdo_pkg::ctl_t  ctl,
	output logic          busy
);
	import mdo_pkg::*;

	// Program labels that branches land on.
	localparam logic [PC_W-1:0] PC_MAC_G    = 5'd2;
	localparam logic [PC_W-1:0] PC_MAC_D    = 5'd6;
	localparam logic [PC_W-1:0] PC_CORR     = 5'd9;
	localparam logic [PC_W-1:0] PC_MAC_C    = 5'd11;
	localparam logic [PC_W-1:0] PC_RATE     = 5'd13;
	localparam logic [PC_W-1:0] PC_MAC_M    = 5'd15;
	localparam logic [PC_W-1:0] PC_MAC_F    = 5'd19;
	localparam logic [PC_W-1:0] PC_NONE     = 5'd0;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	ctl_t            word;
	logic            take;

	function automatic ctl_t mk(input op_t op, input asel_t a, input bsel_t b,
			input logic f24, input cond_t c, input logic [PC_W-1:0] t);
		ctl_t w;
		w.op     = op;
		w.asel   = a;
		w.bsel   = b;
		w.frac24 = f24;
		w.cond   = c;
		w.target = t;
		return w;
	endfunction

	// Observer program: residual, gain product, optional integration,
	// optional correction, momentum update, output filter, emit.
	function automatic ctl_t rom(input logic [PC_W-1:0] pc);
		case (pc)
			5'd0:  return mk(OP_RES,  A_R,    B_GAIN,   1'b0, COND_NEXT,     PC_NONE);
			5'd1:  return mk(OP_MLD,  A_R,    B_GAIN,   1'b0, COND_NEXT,     PC_NONE);
			5'd2:  return mk(OP_MAC,  A_R,    B_GAIN,   1'b0, COND_MUL_MORE, PC_MAC_G);
			5'd3:  return mk(OP_RND,  A_R,    B_GAIN,   1'b0, COND_NEXT,     PC_NONE);
			5'd4:  return mk(OP_GSET, A_R,    B_GAIN,   1'b0, COND_NOT_INT,  PC_CORR);
			5'd5:  return mk(OP_MLD,  A_D,    B_STEP,   1'b1, COND_NEXT,     PC_NONE);
			5'd6:  return mk(OP_MAC,  A_D,    B_STEP,   1'b1, COND_MUL_MORE, PC_MAC_D);
			5'd7:  return mk(OP_RND,  A_D,    B_STEP,   1'b1, COND_NEXT,     PC_NONE);
			5'd8:  return mk(OP_DINT, A_D,    B_STEP,   1'b1, COND_NEXT,     PC_NONE);
			5'd9:  return mk(OP_CLRP, A_R,    B_CGAIN,  1'b0, COND_NOT_CORR, PC_RATE);
			5'd10: return mk(OP_MLD,  A_R,    B_CGAIN,  1'b0, COND_NEXT,     PC_NONE);
			5'd11: return mk(OP_MAC,  A_R,    B_CGAIN,  1'b0, COND_MUL_MORE, PC_MAC_C);
			5'd12: return mk(OP_RND,  A_R,    B_CGAIN,  1'b0, COND_NEXT,     PC_NONE);
			5'd13: return mk(OP_RATE, A_RATE, B_STEP,   1'b1, COND_NEXT,     PC_NONE);
			5'd14: return mk(OP_MLD,  A_RATE, B_STEP,   1'b1, COND_NEXT,     PC_NONE);
			5'd15: return mk(OP_MAC,  A_RATE, B_STEP,   1'b1, COND_MUL_MORE, PC_MAC_M);
			5'd16: return mk(OP_RND,  A_RATE, B_STEP,   1'b1, COND_NEXT,     PC_NONE);
			5'd17: return mk(OP_MOM,  A_RATE, B_STEP,   1'b1, COND_NEXT,     PC_NONE);
			5'd18: return mk(OP_MLD,  A_DF,   B_SMOOTH, 1'b1, COND_NEXT,     PC_NONE);
			5'd19: return mk(OP_MAC,  A_DF,   B_SMOOTH, 1'b1, COND_MUL_MORE, PC_MAC_F);
			5'd20: return mk(OP_RND,  A_DF,   B_SMOOTH, 1'b1, COND_NEXT,     PC_NONE);
			5'd21: return mk(OP_FILT, A_DF,   B_SMOOTH, 1'b1, COND_NEXT,     PC_NONE);
			5'd22: return mk(OP_EMIT, A_R,    B_GAIN,   1'b0, COND_END,      PC_NONE);
			default: return mk(OP_NOP, A_R,   B_GAIN,   1'b0, COND_END,      PC_NONE);
		endcase
	endfunction

	assign word = rom(pc_q);
	assign busy = busy_q;

	// Idle steps issue no datapath operation.
	always_comb begin
		if (busy_q) begin
			ctl = word;
		end else begin
			ctl = mk(OP_NOP, A_R, B_GAIN, 1'b0, COND_END, PC_NONE);
		end
	end

	// Branch decision for the current step.
	always_comb begin
		case (word.cond)
			COND_NOT_INT:  take = !stat.integrate_on;
			COND_NOT_CORR: take = !stat.correction_on;
			COND_MUL_MORE: take = !stat.mul_last;
			default:       take = 1'b0;
		endcase
	end

	// Step counter; the final step holds while the output register is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end
		end else if (word.cond == COND_END) begin
			if (!stat.out_full) begin
				busy_q <= 1'b0;
			end
		end else if (take) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

### design/mdo_datapath.sv
`timescale 1ns / 1ps
// Observer datapath: per-channel state, shared multiplier with rounding,
// shared saturating adder and the output register.
// Depends on mdo_pkg; driven step by step by mdo_seq.
module mdo_datapath #(
	parameter int CHANNELS   = 6,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mdo_pkg::CH_W-1:0]     in_channel,
	input  logic signed [DATA_WIDTH-1:0] in_meas,
	input  logic signed [DATA_WIDTH-1:0] in_drive,
	input  logic signed [DATA_WIDTH-1:0] in_bias,
	input  mdo_pkg::cfg_t                cfg,
	input  mdo_pkg::ctl_t                ctl,
	output mdo_pkg::stat_t               stat,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [mdo_pkg::CH_W-1:0]     out_channel,
	output logic signed [DATA_WIDTH-1:0] out_external,
	output logic signed [DATA_WIDTH-1:0] out_raw,
	output logic                         out_saturated
);
	import mdo_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int AW   = W + 2;
	localparam int ND   = (AW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int MAGP = ND * MUL_DIGIT;
	localparam int ACCW = MAGP + MUL_DIGIT;
	localparam int PW   = W + 3;
	localparam int SW   = W + 4;
	localparam int CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DCW  = (ND > 1) ? $clog2(ND) : 1;

	localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = ~SMAX;
	localparam logic [ACCW:0] RND16 = (ACCW+1)'(1) << (FRAC_GAIN - 1);
	localparam logic [ACCW:0] RND24 = (ACCW+1)'(1) << (FRAC_COEF - 1);
	localparam logic [ACCW:0] CAPV  = (ACCW+1)'(1) << (W + 1);

	// Per-channel observer state.
	logic signed [W-1:0] mom_q  [CHANNELS];
	logic signed [W-1:0] dist_q [CHANNELS];
	logic signed [W-1:0] filt_q [CHANNELS];

	// Working registers for the item in flight.
	logic [CH_W-1:0]      ch_q;
	logic signed [W-1:0]  meas_q;
	logic signed [W:0]    db_q;
	logic signed [W-1:0]  r_q;
	logic signed [W-1:0]  d_q;
	logic signed [W-1:0]  rate_q;
	logic signed [W-1:0]  mnew_q;
	logic signed [W-1:0]  fnew_q;
	logic signed [PW-1:0] p_q;
	logic [ACCW-1:0]      acc_q;
	logic [MAGP-1:0]      mag_q;
	logic                 neg_q;
	logic [GAIN_W-1:0]    b_q;
	logic [DCW-1:0]       dcnt_q;
	logic                 clip_q;
	logic                 out_valid_q;

	logic [CIW-1:0]              idx;
	logic                        lin;
	logic signed [W-1:0]         mold;
	logic signed [W-1:0]         dold;
	logic signed [W-1:0]         fold;
	logic signed [SW-1:0]        sum;
	logic signed [W-1:0]         sat_val;
	logic                        sat_clip;
	logic signed [AW-1:0]        a_val;
	logic [AW-1:0]               a_mag;
	logic [GAIN_W-1:0]           b_val;
	logic [MUL_DIGIT-1:0]        digit;
	logic [2*MUL_DIGIT-1:0]      prod;
	logic [ACCW:0]               rsum;
	logic [ACCW:0]               q;
	logic [ACCW:0]               qcap;
	logic signed [PW-1:0]        pmag;
	logic signed [PW-1:0]        p_next;
	logic                        out_full;
	logic                        emit;

	assign idx  = CIW'(ch_q);
	assign lin  = ch_q < LIN_CHANNELS;
	assign mold = mom_q[idx];
	assign dold = dist_q[idx];
	assign fold = filt_q[idx];

	assign out_full = out_valid_q & ~out_ready;
	assign emit     = (ctl.op == OP_EMIT) && !out_full;

	assign stat.integrate_on  = cfg.integrate_on;
	assign stat.correction_on = cfg.correction_on;
	assign stat.mul_last      = (dcnt_q == '0);
	assign stat.out_full      = out_full;

	// Shared adder feeding the single saturator.
	always_comb begin
		case (ctl.op)
			OP_RES:  sum = SW'(meas_q) - SW'(mold);
			OP_GSET: sum = SW'(p_q);
			OP_DINT: sum = SW'(dold) + SW'(p_q);
			OP_RATE: sum = SW'(db_q) + SW'(d_q) + SW'(p_q);
			OP_MOM:  sum = SW'(mold) + SW'(p_q);
			OP_FILT: sum = SW'(fold) + SW'(p_q);
			default: sum = '0;
		endcase
	end

	// Clip to the data width and flag any clipping.
	always_comb begin
		if (sum > SMAX) begin
			sat_val  = SMAX[W-1:0];
			sat_clip = 1'b1;
		end else if (sum < SMIN) begin
			sat_val  = SMIN[W-1:0];
			sat_clip = 1'b1;
		end else begin
			sat_val  = sum[W-1:0];
			sat_clip = 1'b0;
		end
	end

	// Multiplier operand selection; A is split into sign and magnitude.
	always_comb begin
		case (ctl.asel)
			A_R:     a_val = AW'(r_q);
			A_D:     a_val = AW'(d_q);
			A_RATE:  a_val = AW'(rate_q);
			A_DF:    a_val = -AW'(d_q) - AW'(fold);
			default: a_val = AW'(r_q);
		endcase
		a_mag = a_val[AW-1] ? $unsigned(-a_val) : $unsigned(a_val);
		case (ctl.bsel)
			B_GAIN:   b_val = lin ? cfg.force_gain : cfg.torque_gain;
			B_STEP:   b_val = GAIN_W'(cfg.step_time);
			B_CGAIN:  b_val = lin ? cfg.lin_corr_gain : cfg.ang_corr_gain;
			B_SMOOTH: b_val = GAIN_W'(cfg.smoothing);
			default:  b_val = cfg.force_gain;
		endcase
	end

	// One digit of the magnitude times B per multiply-accumulate step.
	assign digit = mag_q[MAGP-1 -: MUL_DIGIT];
	assign prod  = digit * b_q;

	// Round half away from zero, then cap the magnitude well beyond the
	// data range so that every later saturation still clips the same way.
	always_comb begin
		rsum   = {1'b0, acc_q} + (ctl.frac24 ? RND24 : RND16);
		q      = ctl.frac24 ? (rsum >> FRAC_COEF) : (rsum >> FRAC_GAIN);
		qcap   = (q > CAPV) ? CAPV : q;
		pmag   = $signed({1'b0, qcap[W+1:0]});
		p_next = neg_q ? -pmag : pmag;
	end

	// Working registers, advanced by the current microcode operation.
	always_ff @(posedge clk) begin
		if (start) begin
			ch_q   <= in_channel;
			meas_q <= in_meas;
			db_q   <= (W+1)'(in_drive) - (W+1)'(in_bias);
			clip_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_RES: begin
					r_q    <= sat_val;
					clip_q <= clip_q | sat_clip;
				end
				OP_MLD: begin
					mag_q  <= MAGP'(a_mag);
					neg_q  <= a_val[AW-1];
					b_q    <= b_val;
					acc_q  <= '0;
					dcnt_q <= DCW'(ND - 1);
				end
				OP_MAC: begin
					acc_q  <= {acc_q[ACCW-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}} + ACCW'(prod);
					mag_q  <= mag_q << MUL_DIGIT;
					dcnt_q <= dcnt_q - 1'b1;
				end
				OP_RND: begin
					p_q <= p_next;
				end
				OP_CLRP: begin
					p_q <= '0;
				end
				OP_GSET, OP_DINT: begin
					d_q    <= sat_val;
					clip_q <= clip_q | sat_clip;
				end
				OP_RATE: begin
					rate_q <= sat_val;
					clip_q <= clip_q | sat_clip;
				end
				OP_MOM: begin
					mnew_q <= sat_val;
					clip_q <= clip_q | sat_clip;
				end
				OP_FILT: begin
					fnew_q <= sat_val;
					clip_q <= clip_q | sat_clip;
				end
				default: begin
				end
			endcase
		end
		if (emit) begin
			out_channel   <= ch_q;
			out_external  <= fnew_q;
			out_raw       <= d_q;
			out_saturated <= clip_q;
		end
	end

	// Channel state commit and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				mom_q[i]  <= '0;
				dist_q[i] <= '0;
				filt_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else if (emit) begin
			mom_q[idx]  <= mnew_q;
			dist_q[idx] <= d_q;
			filt_q[idx] <= fnew_q;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
